FILE: src/pctd_pkg.sv
package pctd_pkg;

  localparam int MAX_CODE_LEN = 7;
  localparam int SYMBOL_BYTES = 4;

  localparam int SYM_W       = 8 * SYMBOL_BYTES;
  localparam int CODE_W      = 8;
  localparam int DATA_W      = 8;
  localparam int CNT_W       = 32;
  localparam int TABLE_DEPTH = 2 ** CODE_W;
  localparam int LEN_W       = $clog2(MAX_CODE_LEN + 1);
  localparam int BIT_CNT_W   = $clog2(DATA_W);

  // markers below this hold an empty code
  localparam logic [CODE_W-1:0] MIN_MARKER = CODE_W'(2);

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_DECODE  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic {
    KIND_SYMBOL = 1'b0,
    KIND_ERROR  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC,
    ST_FLUSH
  } state_e;

endpackage

FILE: src/pctd_in_if.sv
interface pctd_in_if;
  import pctd_pkg::*;

  logic                    valid;
  logic                    ready;
  req_e                    req_type;
  logic [CODE_W-1:0]       code_byte;
  logic [SYM_W-1:0]        symbol_in;
  logic [DATA_W-1:0]       data_byte;

  modport source (output valid, req_type, code_byte, symbol_in, data_byte, input ready);
  modport sink   (input valid, req_type, code_byte, symbol_in, data_byte, output ready);
endinterface

FILE: src/pctd_out_if.sv
interface pctd_out_if;
  import pctd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_out;
  kind_e            result_kind;
  logic             last_of_run;
  logic             stream_done;

  modport source (output valid, symbol_out, result_kind, last_of_run, stream_done,
                  input ready);
  modport sink   (input valid, symbol_out, result_kind, last_of_run, stream_done,
                  output ready);
endinterface

FILE: src/pctd_cfg_if.sv
interface pctd_cfg_if;
  import pctd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] symbols_expected;

  modport source (output valid, symbols_expected, input ready);
  modport sink   (input valid, symbols_expected, output ready);
endinterface

FILE: src/pctd_ram.sv
module pctd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/prefix_code_table_decoder_unit.sv
// Prefix-code table decoder. Load, restart and clear-table requests are each handled on acceptance;
// clearing the table resets all 256 entry valid flags at once, so there is no clearing pass.
// A decode request moves the data byte through a bit shifter, one bit per cycle through the code
// accumulator and the entry valid lookup unless a found result waits on a stalled result side,
// and a final flush state marks the last result of the byte while the next request is taken.
// A matched symbol is read from the table memory, one read port, registered. A byte that
// arrives after the stream has finished passes through the decode and flush states; a byte whose
// symbol ends the stream stops at that bit and goes straight to the flush state.
// A stall on the result side can hold back the byte being decoded.
module prefix_code_table_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pctd_in_if.sink    in_i,
  pctd_out_if.source out_o,
  pctd_cfg_if.sink   cfg_i
);
  import pctd_pkg::*;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        expected_q;
  logic [CNT_W-1:0]        decoded_q, decoded_d;
  logic [MAX_CODE_LEN-1:0] accum_q, accum_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [DATA_W-1:0]       data_q, data_d;
  logic [BIT_CNT_W-1:0]    bit_cnt_q, bit_cnt_d;
  logic [TABLE_DEPTH-1:0]  valid_q, valid_d;
  logic                    pend_v_q, pend_v_d;
  logic                    pend_err_q, pend_err_d;
  logic                    pend_done_q, pend_done_d;
  logic                    out_v_q, out_v_d;
  logic [SYM_W-1:0]        out_sym_q, out_sym_d;
  kind_e                   out_kind_q, out_kind_d;
  logic                    out_last_q, out_last_d;
  logic                    out_done_q, out_done_d;

  logic                    out_free;
  logic                    active;
  logic                    is_err;
  logic                    hit;
  logic                    hit_done;
  logic                    res;
  logic [MAX_CODE_LEN-1:0] accum_new;
  logic [LEN_W-1:0]        len_new;
  logic [CODE_W-1:0]       idx;
  logic [CNT_W-1:0]        decoded_inc;
  logic                    in_ready;
  logic                    accept;
  logic                    ram_we;
  logic                    ram_re;
  logic [SYM_W-1:0]        ram_rdata;

  pctd_ram #(
    .WIDTH (SYM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.code_byte),
    .wdata_i (in_i.symbol_in),
    .re_i    (ram_re),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  assign out_free    = !out_v_q || out_o.ready;
  assign active      = decoded_q < expected_q;
  assign is_err      = (len_q == LEN_W'(MAX_CODE_LEN));
  assign accum_new   = {accum_q[MAX_CODE_LEN-2:0], data_q[DATA_W-1]};
  assign len_new     = LEN_W'(len_q + 1'b1);
  assign idx         = (CODE_W'(1) << len_new) | CODE_W'(accum_new);
  assign hit         = !is_err && valid_q[idx];
  assign decoded_inc = CNT_W'(decoded_q + 1'b1);
  assign hit_done    = decoded_inc >= expected_q;
  assign res         = is_err || hit;

  assign in_ready = (state_q == ST_IDLE) ||
                    ((state_q == ST_FLUSH) && (!pend_v_q || out_free));
  assign accept   = in_i.valid && in_ready;

  always_comb begin
    state_d     = state_q;
    decoded_d   = decoded_q;
    accum_d     = accum_q;
    len_d       = len_q;
    data_d      = data_q;
    bit_cnt_d   = bit_cnt_q;
    valid_d     = valid_q;
    pend_v_d    = pend_v_q;
    pend_err_d  = pend_err_q;
    pend_done_d = pend_done_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_sym_d   = out_sym_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_DEC: begin
        if (!active) begin
          state_d = ST_FLUSH;
        end else if (!(res && pend_v_q && !out_free)) begin
          data_d    = data_q << 1;
          bit_cnt_d = BIT_CNT_W'(bit_cnt_q + 1'b1);
          if (bit_cnt_q == BIT_CNT_W'(DATA_W - 1)) begin
            state_d = ST_FLUSH;
          end
          if (is_err) begin
            accum_d = '0;
            len_d   = '0;
          end else if (hit) begin
            accum_d   = '0;
            len_d     = '0;
            decoded_d = decoded_inc;
            ram_re    = 1'b1;
            if (hit_done) begin
              state_d = ST_FLUSH;
            end
          end else begin
            accum_d = accum_new;
            len_d   = len_new;
          end
          if (res) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_sym_d  = pend_err_q ? '0 : ram_rdata;
              out_kind_d = pend_err_q ? KIND_ERROR : KIND_SYMBOL;
              out_last_d = 1'b0;
              out_done_d = pend_done_q;
            end
            pend_v_d    = 1'b1;
            pend_err_d  = is_err;
            pend_done_d = hit && hit_done;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_sym_d  = pend_err_q ? '0 : ram_rdata;
          out_kind_d = pend_err_q ? KIND_ERROR : KIND_SYMBOL;
          out_last_d = 1'b1;
          out_done_d = pend_done_q;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (accept) begin
      unique case (in_i.req_type)
        REQ_LOAD: begin
          if (in_i.code_byte >= MIN_MARKER) begin
            ram_we                   = 1'b1;
            valid_d[in_i.code_byte]  = 1'b1;
          end
          state_d = ST_IDLE;
        end
        REQ_DECODE: begin
          data_d    = in_i.data_byte;
          bit_cnt_d = '0;
          state_d   = ST_DEC;
        end
        REQ_RESTART: begin
          accum_d   = '0;
          len_d     = '0;
          decoded_d = '0;
          state_d   = ST_IDLE;
        end
        REQ_CLEAR: begin
          valid_d = '0;
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      expected_q <= '0;
      decoded_q  <= '0;
      accum_q    <= '0;
      len_q      <= '0;
      bit_cnt_q  <= '0;
      valid_q    <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      decoded_q <= decoded_d;
      accum_q   <= accum_d;
      len_q     <= len_d;
      bit_cnt_q <= bit_cnt_d;
      valid_q   <= valid_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      if (cfg_i.valid) begin
        expected_q <= cfg_i.symbols_expected;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q      <= data_d;
    pend_err_q  <= pend_err_d;
    pend_done_q <= pend_done_d;
    out_sym_q   <= out_sym_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
  end

  assign in_i.ready        = in_ready;
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_v_q;
  assign out_o.symbol_out  = out_sym_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.stream_done = out_done_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending result left behind in idle");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_kind_q == KIND_ERROR)) |-> ((out_sym_q == '0) && !out_done_q))
    else $error("error result carries symbol or done flag");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_CODE_LEN))
    else $error("code length beyond maximum");

  a_busy_in_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC) |-> !in_i.ready)
    else $error("request taken while decoding a byte");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH) && pend_v_q && out_free) |=> (out_v_q && out_last_q))
    else $error("final result of a byte not marked last");

endmodule
